FILE: src/urif_pkg.sv
// Shared types and constants for the UART receive idle-timeout framer.
// Used by urif_ctrl, urif_dpath and uart_rx_idle_timeout_framer_core.
// No dependencies.
package urif_pkg;

    // Sizes fixed by the interface
    localparam int unsigned TIMEOUT_W            = 16;
    localparam int unsigned LENGTH_W             = 9;
    localparam int unsigned BYTE_W               = 8;
    localparam int unsigned BUFFER_DEPTH_DEFAULT = 256;
    localparam int unsigned BUFFER_DEPTH_MAX     = 1 << 15;

    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RESET = 16'd500;

    // Request opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Input request
    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] read_index;
    } in_item_t;

    // Result
    typedef struct packed {
        logic                frame_done;
        logic [LENGTH_W-1:0] frame_length;
        logic [BYTE_W-1:0]   read_data;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic do_byte;
        logic do_tick;
        logic do_read;
        logic do_clear;
        logic cfg_write;
    } cmd_t;

endpackage

FILE: src/urif_ctrl.sv
// Handshake controller for the UART receive framer.
// Depends on urif_pkg; drives the command struct into urif_dpath.
module urif_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        in_op,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output urif_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_OUT  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Op decode into commands
    always_comb
    begin
        cmd.do_byte   = accept && (in_op == urif_pkg::OP_BYTE);
        cmd.do_tick   = accept && (in_op == urif_pkg::OP_TICK);
        cmd.do_read   = accept && (in_op == urif_pkg::OP_READ);
        cmd.do_clear  = accept && (in_op == urif_pkg::OP_CLEAR);
        cmd.cfg_write = cfg_valid && cfg_ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/urif_dpath.sv
// Datapath of the UART receive framer: frame store, counters, idle timer.
// Depends on urif_pkg; commanded by urif_ctrl.
module urif_dpath
#(
    parameter int unsigned BUFFER_DEPTH = urif_pkg::BUFFER_DEPTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  urif_pkg::cmd_t                   cmd,
    input  urif_pkg::in_item_t               in_data,
    input  logic [urif_pkg::TIMEOUT_W-1:0]   cfg_data,
    output urif_pkg::out_item_t              out_data
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

    // Frame store, reset contents undefined
    logic [urif_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];

    logic [urif_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [CW-1:0]                  count_reg,   count_next;
    logic                           done_reg,    done_next;
    logic [urif_pkg::TIMEOUT_W-1:0] idle_reg,    idle_next;
    logic                           running_reg, running_next;
    logic                           hit_reg;
    logic [urif_pkg::BYTE_W-1:0]    rd_q;

    logic                           not_full;
    logic                           store_en;
    logic [urif_pkg::TIMEOUT_W-1:0] idle_inc;
    logic [15:0]                    idx_wide;
    logic [15:0]                    len_wide;
    logic                           rd_hit;

    assign not_full = (count_reg < CW'(BUFFER_DEPTH));
    assign store_en = cmd.do_byte && !done_reg && not_full;
    assign idle_inc = idle_reg + 16'd1;
    assign idx_wide = 16'(in_data.read_index);
    assign len_wide = 16'(count_reg);
    assign rd_hit   = (idx_wide < len_wide);

    // Frame state update
    always_comb
    begin
        count_next   = count_reg;
        done_next    = done_reg;
        idle_next    = idle_reg;
        running_next = running_reg;
        if (cmd.do_byte && !done_reg)
        begin
            if (not_full)
            begin
                idle_next  = '0;
                count_next = count_reg + CW'(1);
                if (count_reg == '0)
                begin
                    running_next = 1'b1;
                end
            end
            else
            begin
                // byte on a full store closes the frame and is dropped
                done_next    = 1'b1;
                running_next = 1'b0;
                idle_next    = '0;
            end
        end
        else if (cmd.do_tick && running_reg)
        begin
            if (idle_inc >= timeout_reg)
            begin
                done_next    = 1'b1;
                running_next = 1'b0;
                idle_next    = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        else if (cmd.do_clear)
        begin
            count_next   = '0;
            done_next    = 1'b0;
            idle_next    = '0;
            running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= urif_pkg::IDLE_TIMEOUT_RESET;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            idle_reg    <= '0;
            running_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                timeout_reg <= cfg_data;
            end
            count_reg   <= count_next;
            done_reg    <= done_next;
            idle_reg    <= idle_next;
            running_reg <= running_next;
            // read data is only shown for an in-range read
            if (cmd.do_byte || cmd.do_tick || cmd.do_read || cmd.do_clear)
            begin
                hit_reg <= cmd.do_read && rd_hit;
            end
        end
    end

    // Store write and registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[AW-1:0]] <= in_data.rx_byte;
        end
        if (cmd.do_read)
        begin
            rd_q <= mem[idx_wide[AW-1:0]];
        end
    end

    // Result
    always_comb
    begin
        out_data.frame_done   = done_reg;
        out_data.frame_length = len_wide[urif_pkg::LENGTH_W-1:0];
        out_data.read_data    = hit_reg ? rd_q : '0;
    end

endmodule

FILE: src/uart_rx_idle_timeout_framer_core.sv
// UART receive framer with idle timeout: top level.
// The result is valid in the cycle after a request is taken; a new request is taken only after
// the result has been taken, since the controller stalls input while a result is pending.
// Reset (rst_n, async, low): frame open and empty, timer stopped, idle_timeout = 500.
// The frame store is not cleared; only entries written in the current frame are read.
// Depends on urif_pkg, urif_ctrl and urif_dpath.
module uart_rx_idle_timeout_framer_core
#(
    parameter int unsigned BUFFER_DEPTH = urif_pkg::BUFFER_DEPTH_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  urif_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output urif_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [urif_pkg::TIMEOUT_W-1:0]  cfg_data
);

    urif_pkg::cmd_t cmd;

    urif_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    urif_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

    // A taken request yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after request");

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");

    // Clear reopens an empty frame
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.op == urif_pkg::OP_CLEAR) |=>
        (!out_data.frame_done && out_data.frame_length == '0))
        else $error("clear did not reopen frame");

    // Only reads return data
    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.op != urif_pkg::OP_READ) |=>
        (out_data.read_data == '0))
        else $error("read data on a non-read request");

endmodule

FILE: tb/uart_rx_idle_timeout_framer_core_tb.sv
`timescale 1ns / 100ps
// Testbench for uart_rx_idle_timeout_framer_core: a predictor of the framer checks every result.
// Directed requests, then random frames under several idle timeouts and stall patterns.
// Depends on urif_pkg and the framer RTL.
module uart_rx_idle_timeout_framer_core_tb;

    localparam int unsigned STORE_DEPTH = urif_pkg::BUFFER_DEPTH_DEFAULT;

    // Stall patterns for the two channels
    localparam logic [1:0] IDLE_RX_HEAVY = 2'd0;   // sender 7%, receiver 82%
    localparam logic [1:0] IDLE_TX_HEAVY = 2'd1;   // sender 82%, receiver 7%
    localparam logic [1:0] IDLE_NONE     = 2'd2;

    localparam int unsigned HOLD_CYCLES = 80;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    urif_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    urif_pkg::out_item_t            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [urif_pkg::TIMEOUT_W-1:0] cfg_data = '0;

    logic [1:0]                     idle_mode = IDLE_NONE;
    logic                           hold_request = 1'b0;
    logic [7:0]                     hold_left = '0;

    urif_pkg::in_item_t             pending_requests[$];
    urif_pkg::out_item_t            expected_results[$];

    // Predictor state
    logic [urif_pkg::TIMEOUT_W-1:0] model_timeout = urif_pkg::IDLE_TIMEOUT_RESET;
    logic [urif_pkg::LENGTH_W-1:0]  model_count = '0;
    logic                           model_done = 1'b0;
    logic [urif_pkg::TIMEOUT_W-1:0] model_idle = '0;
    logic                           model_running = 1'b0;
    logic [urif_pkg::BYTE_W-1:0]    model_store [STORE_DEPTH];

    int unsigned          cur_timeout = urif_pkg::IDLE_TIMEOUT_RESET;
    int unsigned          requests_queued = 0;
    int unsigned          requests_taken = 0;
    int unsigned          results_checked = 0;
    int unsigned          closed_results = 0;
    int unsigned          longest_frame = 0;
    int unsigned          mismatches = 0;
    urif_pkg::out_item_t  want;

    uart_rx_idle_timeout_framer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Next state and result of the framer for one request
    function automatic urif_pkg::out_item_t framer_predict(input urif_pkg::in_item_t req);
        urif_pkg::out_item_t res;
        res = '0;
        case (req.op)
            urif_pkg::OP_BYTE:
            begin
                if (!model_done)
                begin
                    if (model_count < STORE_DEPTH)
                    begin
                        model_idle = '0;
                        if (model_count == 0)
                            model_running = 1'b1;
                        model_store[model_count[7:0]] = req.rx_byte;
                        model_count = model_count + 1'b1;
                    end
                    else
                    begin
                        // byte into a full store closes the frame and is dropped
                        model_done    = 1'b1;
                        model_running = 1'b0;
                        model_idle    = '0;
                    end
                end
            end
            urif_pkg::OP_TICK:
            begin
                if (model_running)
                begin
                    model_idle = model_idle + 1'b1;
                    if (model_idle >= model_timeout)
                    begin
                        model_done    = 1'b1;
                        model_running = 1'b0;
                        model_idle    = '0;
                    end
                end
            end
            urif_pkg::OP_READ:
            begin
                if (req.read_index < model_count)
                    res.read_data = model_store[req.read_index];
            end
            default:
            begin
                // clear keeps the store contents
                model_count   = '0;
                model_done    = 1'b0;
                model_idle    = '0;
                model_running = 1'b0;
            end
        endcase
        res.frame_done   = model_done;
        res.frame_length = model_count;
        return res;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_RX_HEAVY: return $urandom_range(0, 99) < 7;
            IDLE_TX_HEAVY: return $urandom_range(0, 99) < 82;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            IDLE_RX_HEAVY: return $urandom_range(0, 99) < 82;
            IDLE_TX_HEAVY: return $urandom_range(0, 99) < 7;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatches++;
        if (mismatches <= 200)
            $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
                     $realtime, what, results_checked, got, exp_val);
    endtask

    // Driver: predicts each taken request, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(framer_predict(in_data));
                requests_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && !sender_idles())
                begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= HOLD_CYCLES[7:0];
        else if (hold_left != 0)
            hold_left <= hold_left - 1'b1;
    end

    // Monitor: compares each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", out_data, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.frame_done !== want.frame_done)
                        report_mismatch("frame_done", out_data.frame_done, want.frame_done);
                    if (out_data.frame_length !== want.frame_length)
                        report_mismatch("frame_length", out_data.frame_length,
                                        want.frame_length);
                    if (out_data.read_data !== want.read_data)
                        report_mismatch("read_data", out_data.read_data, want.read_data);
                    if (want.frame_done)
                        closed_results++;
                    if (want.frame_length > longest_frame)
                        longest_frame = want.frame_length;
                end
                results_checked++;
            end
            out_stall <= (hold_left > 1) || receiver_idles();
        end
    end

    task automatic queue_request(input logic [1:0] op, input int unsigned rx,
                                 input int unsigned idx);
        urif_pkg::in_item_t req;
        req.op         = op;
        req.rx_byte    = rx[7:0];
        req.read_index = idx[7:0];
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Waits until nothing is offered or outstanding
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_idle_timeout(input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[urif_pkg::TIMEOUT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        model_timeout  = value[urif_pkg::TIMEOUT_W-1:0];
        cur_timeout    = value;
    endtask

    // One frame: clear, bytes with short idle gaps, reads, idle run, late traffic; or a noise burst
    task automatic queue_frame(input bit force_full);
        int unsigned n_bytes;
        int unsigned max_gap;
        int unsigned hi_idx;
        int unsigned i;
        if (!force_full && $urandom_range(0, 6) == 0)
        begin
            // noise burst
            repeat ($urandom_range(1, 6))
                queue_request(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                              $urandom_range(0, 255));
            return;
        end
        queue_request(urif_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
        if (force_full || $urandom_range(0, 9) == 0)
            n_bytes = STORE_DEPTH - 1 + $urandom_range(0, 3);
        else
            n_bytes = $urandom_range(0, 16);
        max_gap = (cur_timeout > 8) ? 7 : cur_timeout - 1;
        for (i = 0; i < n_bytes; i++)
        begin
            queue_request(urif_pkg::OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 255));
            if (max_gap != 0 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, max_gap))
                    queue_request(urif_pkg::OP_TICK, $urandom_range(0, 255),
                                  $urandom_range(0, 255));
        end
        hi_idx = (n_bytes < STORE_DEPTH) ? n_bytes : STORE_DEPTH - 1;
        repeat ($urandom_range(1, 5))
            queue_request(urif_pkg::OP_READ, $urandom_range(0, 255),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, hi_idx));
        if (cur_timeout <= 64)
            repeat (cur_timeout + $urandom_range(0, 2))
                queue_request(urif_pkg::OP_TICK, $urandom_range(0, 255),
                              $urandom_range(0, 255));
        else
            repeat ($urandom_range(0, 5))
                queue_request(urif_pkg::OP_TICK, $urandom_range(0, 255),
                              $urandom_range(0, 255));
        repeat ($urandom_range(0, 3))
            queue_request($urandom_range(0, 1) ? urif_pkg::OP_BYTE : urif_pkg::OP_READ,
                          $urandom_range(0, 255), $urandom_range(0, hi_idx));
    endtask

    task automatic run_segment(input int unsigned timeout, input logic [1:0] mode,
                               input int unsigned budget, input bit force_full);
        int unsigned stop_at;
        wait_drained();
        write_idle_timeout(timeout);
        idle_mode <= mode;
        stop_at = requests_queued + budget;
        queue_frame(force_full);
        while (requests_queued < stop_at)
            queue_frame(1'b0);
    endtask

    // Stimulus
    initial
    begin
        for (int k = 0; k < STORE_DEPTH; k++)
            model_store[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset timeout of 500
        queue_request(urif_pkg::OP_TICK, 8'h00, 8'h00);    // timer stopped
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h00);    // empty frame reads zero
        queue_request(urif_pkg::OP_BYTE, 8'h00, 8'hFF);
        queue_request(urif_pkg::OP_BYTE, 8'hFF, 8'h00);
        queue_request(urif_pkg::OP_BYTE, 8'hA5, 8'h00);
        queue_request(urif_pkg::OP_READ, 8'hFF, 8'h00);
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h01);
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h02);
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h03);    // index equal to length
        queue_request(urif_pkg::OP_READ, 8'hFF, 8'hFF);    // index past length
        queue_request(urif_pkg::OP_TICK, 8'hFF, 8'hFF);
        queue_request(urif_pkg::OP_TICK, 8'h00, 8'h00);
        queue_request(urif_pkg::OP_CLEAR, 8'hFF, 8'hFF);   // stops a running timer
        queue_request(urif_pkg::OP_TICK, 8'h00, 8'h00);
        queue_request(urif_pkg::OP_BYTE, 8'h5A, 8'h00);
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h00);
        wait_drained();

        // Directed, short timeout: close on idle, then bytes are ignored
        write_idle_timeout(2);
        queue_request(urif_pkg::OP_TICK, 8'h00, 8'h00);
        queue_request(urif_pkg::OP_TICK, 8'h00, 8'h00);
        queue_request(urif_pkg::OP_BYTE, 8'h11, 8'h00);
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h01);
        queue_request(urif_pkg::OP_READ, 8'h00, 8'h00);
        queue_request(urif_pkg::OP_CLEAR, 8'h00, 8'h00);

        // Random frames under several timeouts and stall patterns
        run_segment(1, IDLE_RX_HEAVY, 300, 1'b0);
        run_segment(65535, IDLE_RX_HEAVY, 350, 1'b1);
        run_segment(7, IDLE_TX_HEAVY, 350, 1'b0);
        run_segment(2, IDLE_TX_HEAVY, 250, 1'b0);
        run_segment(33, IDLE_NONE, 600, 1'b1);

        // Receiver holds off while the sender keeps offering
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d results from %0d requests; %0d closed, longest frame %0d.",
                 results_checked, requests_taken, closed_results, longest_frame);
        $display("Idle timeouts 1 to 65535 under three stall patterns and one long output hold-off.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results still expected.", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
src/urif_pkg.sv
src/urif_ctrl.sv
src/urif_dpath.sv
src/uart_rx_idle_timeout_framer_core.sv
tb/uart_rx_idle_timeout_framer_core_tb.sv
